@@ rtl/wma_pkg.sv @@
// shared types and constants of the windowed multichannel averager
package wma_pkg;

	localparam int CHANNELS    = 6;
	localparam int SAMPLE_BITS = 12;
	localparam int COUNT_BITS  = 20;
	localparam int SUM_BITS    = 32;
	localparam int TIME_BITS   = 32;
	localparam int MEAN_BITS   = 16;
	localparam int FRAC_BITS   = 4;

	localparam int NUM_BITS = SUM_BITS + FRAC_BITS;
	localparam int LIM_BITS = COUNT_BITS + MEAN_BITS;
	localparam int CMP_BITS = (NUM_BITS > LIM_BITS) ? NUM_BITS : LIM_BITS;
	localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STEP_BITS = $clog2(MEAN_BITS);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [SUM_BITS-1:0]    sum_t;
	typedef logic [TIME_BITS-1:0]   time_t;
	typedef logic [MEAN_BITS-1:0]   mean_t;
	typedef logic [NUM_BITS-1:0]    num_t;
	typedef logic [CH_BITS-1:0]     chan_t;
	typedef logic [STEP_BITS-1:0]   step_t;

	localparam time_t  INTERVAL_RESET = time_t'(4000);
	localparam count_t TALLY_MAX      = {COUNT_BITS{1'b1}};
	localparam mean_t  MEAN_MAX       = {MEAN_BITS{1'b1}};
	localparam chan_t  LAST_CHAN      = chan_t'(CHANNELS - 1);
	localparam step_t  LAST_STEP      = step_t'(MEAN_BITS - 1);

endpackage

@@ rtl/wma_in_if.sv @@
// sample request channel: six readings and the millisecond time
interface wma_in_if;
	import wma_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_1;
	sample_t sample_2;
	sample_t sample_3;
	sample_t sample_4;
	sample_t sample_5;
	sample_t sample_6;
	time_t   now_ms;

	modport source (output valid, sample_1, sample_2, sample_3, sample_4, sample_5, sample_6,
		now_ms, input ready);
	modport sink (input valid, sample_1, sample_2, sample_3, sample_4, sample_5, sample_6,
		now_ms, output ready);
endinterface

@@ rtl/wma_out_if.sv @@
// result request channel: six window means, sample count and drop flag
interface wma_out_if;
	import wma_pkg::*;

	logic   valid;
	logic   ready;
	mean_t  mean_1;
	mean_t  mean_2;
	mean_t  mean_3;
	mean_t  mean_4;
	mean_t  mean_5;
	mean_t  mean_6;
	count_t window_samples;
	logic   samples_dropped;

	modport source (output valid, mean_1, mean_2, mean_3, mean_4, mean_5, mean_6,
		window_samples, samples_dropped, input ready);
	modport sink (input valid, mean_1, mean_2, mean_3, mean_4, mean_5, mean_6,
		window_samples, samples_dropped, output ready);
endinterface

@@ rtl/wma_cfg_if.sv @@
// configuration write channel carrying the report interval
interface wma_cfg_if;
	import wma_pkg::*;

	logic  valid;
	logic  ready;
	time_t interval_ms;

	modport source (output valid, interval_ms, input ready);
	modport sink (input valid, interval_ms, output ready);
endinterface

@@ rtl/windowed_multichannel_averager_unit.sv @@
// windowed multichannel averager: accumulates six channels and reports window means
//
// samples: one request carries a 12-bit reading per channel and the current
//   millisecond time. a request that does not close a window leaves samples
//   ready, so such requests stream at one per cycle while no window is closing.
// results: when now_ms minus the last report time reaches interval_ms, the
//   request closes the window and one result follows, holding each channel's
//   mean as unsigned Q12.4, the sample count and the drop flag.
// cfg: writes interval_ms (reset 4000); always ready, write only while idle.
// samples stays low while a closing request is in work: one restoring divider,
//   one quotient bit per cycle, serves all six channels in turn, with a setup
//   step per channel that skips the divider for an empty or saturating mean.
// the result sits in an output register; the next window accumulates while
//   it waits. if it is still not taken at the next report, the block holds
//   the new means and samples stays low until the receiver takes it.
// a full count drops further samples and flags the window.
// reset clears sums, count, drop flag, report time, and sets interval to 4000.
module windowed_multichannel_averager_unit (
	input logic      clk,
	input logic      arst_n,
	wma_in_if.sink   samples,
	wma_out_if.source results,
	wma_cfg_if.sink  cfg
);
	import wma_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DIV, S_LOAD} state_t;

	state_t state_q;
	time_t  interval_q;
	time_t  last_report_q;
	sum_t   sum_q [CHANNELS];
	count_t tally_q;
	logic   drop_q;
	chan_t  ch_q;
	step_t  step_q;
	count_t rem_q;
	mean_t  quo_q;
	mean_t  mean_q [CHANNELS];

	logic   res_valid_q;
	mean_t  res_mean_q [CHANNELS];
	count_t res_count_q;
	logic   res_drop_q;

	sample_t smp [CHANNELS];
	logic    acc;
	logic    report;
	logic    out_free;
	time_t   elapsed;
	num_t    num;
	logic    num_over;
	logic [COUNT_BITS:0] trial;
	logic [COUNT_BITS:0] diff;
	logic    qbit;
	count_t  rem_next;
	mean_t   quo_next;

	assign smp[0] = samples.sample_1;
	assign smp[1] = samples.sample_2;
	assign smp[2] = samples.sample_3;
	assign smp[3] = samples.sample_4;
	assign smp[4] = samples.sample_5;
	assign smp[5] = samples.sample_6;

	assign samples.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign acc           = samples.valid && samples.ready;
	assign elapsed       = samples.now_ms - last_report_q;
	assign report        = (elapsed >= interval_q);
	assign out_free      = !res_valid_q || results.ready;

	// divider datapath for the channel under work
	assign num      = {sum_q[ch_q], {FRAC_BITS{1'b0}}};
	assign num_over = CMP_BITS'(num) >= CMP_BITS'({tally_q, {MEAN_BITS{1'b0}}});
	assign trial    = {rem_q, quo_q[MEAN_BITS-1]};
	assign diff     = trial - {1'b0, tally_q};
	assign qbit     = (trial >= {1'b0, tally_q});
	assign rem_next = qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
	assign quo_next = {quo_q[MEAN_BITS-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			interval_q    <= INTERVAL_RESET;
			last_report_q <= '0;
			tally_q       <= '0;
			drop_q        <= 1'b0;
			ch_q          <= '0;
			step_q        <= '0;
			res_valid_q   <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				interval_q <= cfg.interval_ms;
			end
			if (state_q == S_LOAD && out_free) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (tally_q != TALLY_MAX) begin
							for (int c = 0; c < CHANNELS; c++) begin
								sum_q[c] <= sum_q[c] + SUM_BITS'(smp[c]);
							end
							tally_q <= tally_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						if (report) begin
							last_report_q <= samples.now_ms;
							ch_q          <= '0;
							state_q       <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					step_q <= '0;
					if (tally_q == '0 || num_over) begin
						mean_q[ch_q] <= (tally_q == '0) ? '0 : MEAN_MAX;
						if (ch_q == LAST_CHAN) begin
							state_q <= S_LOAD;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end else begin
						rem_q   <= COUNT_BITS'(num[NUM_BITS-1:MEAN_BITS]);
						quo_q   <= num[MEAN_BITS-1:0];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						mean_q[ch_q] <= quo_next;
						if (ch_q == LAST_CHAN) begin
							state_q <= S_LOAD;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_CHECK;
						end
					end
				end
				S_LOAD: begin
					if (out_free) begin
						res_mean_q  <= mean_q;
						res_count_q <= tally_q;
						res_drop_q  <= drop_q;
						tally_q     <= '0;
						drop_q      <= 1'b0;
						for (int c = 0; c < CHANNELS; c++) begin
							sum_q[c] <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid           = res_valid_q;
	assign results.mean_1          = res_mean_q[0];
	assign results.mean_2          = res_mean_q[1];
	assign results.mean_3          = res_mean_q[2];
	assign results.mean_4          = res_mean_q[3];
	assign results.mean_5          = res_mean_q[4];
	assign results.mean_6          = res_mean_q[5];
	assign results.window_samples  = res_count_q;
	assign results.samples_dropped = res_drop_q;

	// full count holds through an accepted request
	a_tally_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && tally_q == TALLY_MAX) |=> (tally_q == TALLY_MAX))
		else $error("sample count left saturation");

	// a closing request starts the divider at the first channel
	a_report_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && report) |=> (state_q == S_CHECK && ch_q == '0))
		else $error("report did not start at first channel");

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < tally_q))
		else $error("divider remainder out of range");

	// a loaded result never carries an empty window
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && out_free) |=> (results.valid && results.window_samples != '0))
		else $error("result loaded with empty window");

endmodule

@@ tb/sv/wma_window_checker.sv @@
`timescale 1ns / 1ps
// window checker: predicts the averager's reports from observed requests and compares results
module wma_window_checker (
	input  logic        clk,
	input  logic        arst_n,
	wma_in_if           smp,
	wma_out_if          res,
	wma_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned awaiting
);
	import wma_pkg::*;

	typedef struct packed {
		mean_t [CHANNELS-1:0] mean;
		count_t               window_samples;
		logic                 samples_dropped;
	} window_report_t;

	window_report_t reports_due[$];
	time_t          interval_ms;
	sum_t           channel_sum [CHANNELS];
	count_t         sample_tally;
	time_t          last_report_ms;
	logic           drop_seen;
	int unsigned    failed;

	assign mismatches = failed;

	always @(posedge clk or negedge arst_n) begin
		window_report_t  due;
		window_report_t  seen;
		sample_t         reading [CHANNELS];
		longint unsigned quotient;
		if (!arst_n) begin
			interval_ms    = INTERVAL_RESET;
			sample_tally   = '0;
			last_report_ms = '0;
			drop_seen      = 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				channel_sum[c] = '0;
			end
			reports_due.delete();
			failed   = 0;
			awaiting <= 0;
		end else begin
			if (res.valid && res.ready) begin
				seen.mean = {res.mean_6, res.mean_5, res.mean_4, res.mean_3, res.mean_2,
					res.mean_1};
				seen.window_samples  = res.window_samples;
				seen.samples_dropped = res.samples_dropped;
				if (reports_due.size() == 0) begin
					$display("%0t: result with no report due, window_samples %0d", $time,
						seen.window_samples);
					failed++;
				end else begin
					due = reports_due.pop_front();
					for (int c = 0; c < CHANNELS; c++) begin
						if (seen.mean[c] !== due.mean[c]) begin
							$display("%0t: mean_%0d expected %0d got %0d", $time, c + 1,
								due.mean[c], seen.mean[c]);
							failed++;
						end
					end
					if (seen.window_samples !== due.window_samples) begin
						$display("%0t: window_samples expected %0d got %0d", $time,
							due.window_samples, seen.window_samples);
						failed++;
					end
					if (seen.samples_dropped !== due.samples_dropped) begin
						$display("%0t: samples_dropped expected %0b got %0b", $time,
							due.samples_dropped, seen.samples_dropped);
						failed++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				interval_ms = cfg.interval_ms;
			end
			if (smp.valid && smp.ready) begin
				reading = '{smp.sample_1, smp.sample_2, smp.sample_3, smp.sample_4,
					smp.sample_5, smp.sample_6};
				if (sample_tally != TALLY_MAX) begin
					for (int c = 0; c < CHANNELS; c++) begin
						channel_sum[c] = channel_sum[c] + sum_t'(reading[c]);
					end
					sample_tally++;
				end else begin
					drop_seen = 1'b1;
				end
				if (time_t'(smp.now_ms - last_report_ms) >= interval_ms) begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (sample_tally == '0) begin
							quotient = 0;
						end else begin
							quotient = (longint'(channel_sum[c]) << FRAC_BITS)
								/ longint'(sample_tally);
						end
						due.mean[c]    = (quotient > MEAN_MAX) ? MEAN_MAX : mean_t'(quotient);
						channel_sum[c] = '0;
					end
					due.window_samples  = sample_tally;
					due.samples_dropped = drop_seen;
					reports_due.push_back(due);
					sample_tally   = '0;
					drop_seen      = 1'b0;
					last_report_ms = smp.now_ms;
				end
			end
			awaiting <= reports_due.size();
		end
	end

endmodule

@@ tb/sv/windowed_multichannel_averager_unit_tb.sv @@
`timescale 1ns / 1ps
// testbench top: drives samples, interval writes and result backpressure, gives the verdict
module windowed_multichannel_averager_unit_tb;
	import wma_pkg::*;

	typedef sample_t [CHANNELS-1:0] reading_set_t;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned awaiting;
	int unsigned rx_hold;
	bit          tx_quiet;
	bit          rx_quiet;
	time_t       clock_ms;

	wma_in_if  smp_if ();
	wma_out_if res_if ();
	wma_cfg_if cfg_if ();

	windowed_multichannel_averager_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	wma_window_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp_if),
		.res        (res_if),
		.cfg        (cfg_if),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("windowed_multichannel_averager_unit: mismatch");
		$finish;
	end

	function automatic reading_set_t random_readings();
		reading_set_t vals;
		for (int c = 0; c < CHANNELS; c++) begin
			case ($urandom_range(0, 7))
				0: vals[c] = '0;
				1: vals[c] = '1;
				default: vals[c] = sample_t'($urandom());
			endcase
		end
		return vals;
	endfunction

	task automatic offer(input reading_set_t vals, input time_t now, input int unsigned gap);
		if (gap != 0) begin
			smp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid    <= 1'b1;
		smp_if.sample_1 <= vals[0];
		smp_if.sample_2 <= vals[1];
		smp_if.sample_3 <= vals[2];
		smp_if.sample_4 <= vals[3];
		smp_if.sample_5 <= vals[4];
		smp_if.sample_6 <= vals[5];
		smp_if.now_ms   <= now;
		do @(posedge clk); while (!smp_if.ready);
	endtask

	task automatic settle();
		smp_if.valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_interval(input time_t value);
		settle();
		cfg_if.valid       <= 1'b1;
		cfg_if.interval_ms <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	// result side backpressure
	initial begin
		int unsigned stall;
		res_if.ready <= 1'b0;
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			if (rx_hold != 0) begin
				res_if.ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	initial begin
		time_t        plan [9];
		int unsigned  pick;
		reading_set_t alternating;
		plan        = '{3, 1, 25, '1, 7, 0, 150, 2, 12};
		alternating = {(CHANNELS / 2){12'hAAA, 12'h555}};
		rx_hold  = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		arst_n   = 1'b0;
		smp_if.valid       <= 1'b0;
		smp_if.sample_1    <= '0;
		smp_if.sample_2    <= '0;
		smp_if.sample_3    <= '0;
		smp_if.sample_4    <= '0;
		smp_if.sample_5    <= '0;
		smp_if.sample_6    <= '0;
		smp_if.now_ms      <= '0;
		cfg_if.valid       <= 1'b0;
		cfg_if.interval_ms <= INTERVAL_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// default interval, field extremes
		offer('0, 0, 0);
		offer('1, 3999, 2);
		offer(alternating, 4000, 0);
		set_interval(1);
		offer(random_readings(), 4000, 0);
		offer(random_readings(), 4001, 3);
		// zero interval reports every request
		set_interval(0);
		offer('1, 4001, 0);
		offer('0, 4001, 0);
		// time wraps past 2^32
		set_interval(10);
		offer(random_readings(), 32'hFFFF_FFF8, 0);
		offer(alternating, 32'h0000_0002, 1);
		offer(random_readings(), 32'h0000_000B, 0);
		// hold the window open, then close with the largest interval
		set_interval('1);
		tx_quiet = 1'b1;
		repeat (4) offer(random_readings(), 32'h0000_0002, 0);
		offer(random_readings(), 32'h0000_0001, 0);
		clock_ms = 32'h0000_0001;

		for (int p = 0; p < 9; p++) begin
			set_interval((p == 8) ? time_t'($urandom_range(1, 40)) : plan[p]);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (p == 7) begin
				tx_quiet = 1'b1;
				rx_quiet = 1'b0;
				rx_hold  = 400;
			end
			for (int k = 0; k < 95; k++) begin
				if (k % 30 == 29) begin
					tx_quiet = ($urandom_range(0, 3) == 0);
					rx_quiet = ($urandom_range(0, 3) == 0);
				end
				pick = $urandom_range(0, 19);
				if (pick < 17) begin
					clock_ms += time_t'($urandom_range(0, 4));
				end else if (pick < 19) begin
					clock_ms = time_t'($urandom());
				end else begin
					clock_ms -= time_t'($urandom_range(1, 8));
				end
				offer(random_readings(), clock_ms, tx_quiet ? 0 : $urandom_range(0, 19));
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("windowed_multichannel_averager_unit: match");
		end else begin
			$display("windowed_multichannel_averager_unit: mismatch");
		end
		$finish;
	end

endmodule

@@ windowed_multichannel_averager_unit.f @@
rtl/wma_pkg.sv
rtl/wma_in_if.sv
rtl/wma_out_if.sv
rtl/wma_cfg_if.sv
rtl/windowed_multichannel_averager_unit.sv
tb/sv/wma_window_checker.sv
tb/sv/windowed_multichannel_averager_unit_tb.sv
